FILE: sv/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/gbrf_pkg.sv
// package for the rotated framebuffer glyph blitter
// geometry constants, command and render mode codes, state type; no dependencies
package gbrf_pkg;

    localparam int LANDSCAPE_WIDTH  = 800;
    localparam int LANDSCAPE_HEIGHT = 480;
    localparam int ROW_BYTES        = 100;
    localparam int STORE_BYTES      = LANDSCAPE_HEIGHT * ROW_BYTES;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int IDX_W  = $clog2(STORE_BYTES + LANDSCAPE_WIDTH);
    localparam int LX_W   = $clog2(LANDSCAPE_WIDTH + 1);
    localparam int LY_W   = $clog2(LANDSCAPE_HEIGHT + 1);
    localparam int BASE_W = 12;
    localparam int CW     = 14;

    typedef enum logic [1:0] {
        CMD_GLYPH = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [1:0] MODE_BW       = 2'd0;
    localparam logic [1:0] MODE_GRAY_MSB = 2'd1;
    localparam logic [1:0] MODE_GRAY_LSB = 2'd2;
    localparam logic [1:0] MODE_OFF      = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

FILE: sv/glyph_blit_rotated_framebuffer.sv
// rotated 1-bit framebuffer with glyph blit, pixel write and byte read
// depends on gbrf_pkg and assert_macros.svh
//
//  channel   handshake                     payload
//  command   start in, busy out            i_command .. i_read_address
//  result    o_done strobe, one cycle      o_read_data, o_pixels_written, o_pixels_dropped
//  config    i_cfg_valid in, o_cfg_ready   i_cfg_data (render mode)
//
// a glyph byte walks its pixel slots (8 for 1-bit, 4 for 2-bit packing), fewer
// once the walk runs out of rows; a single pixel passes the walk state, a byte read the
// read state, and an unused command goes straight to done; one pixel read-modify-write
// a cycle on the single framebuffer memory, with write forwarding between slots
// after reset the memory is filled with white while busy is high
// config writes are taken in every cycle; results cannot be stalled
`include "assert_macros.svh"

module glyph_blit_rotated_framebuffer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_command,
    input  logic signed [10:0]   i_pen_x,
    input  logic signed [10:0]   i_pen_y,
    input  logic signed [7:0]    i_glyph_left,
    input  logic signed [7:0]    i_glyph_top,
    input  logic [7:0]           i_glyph_width,
    input  logic [7:0]           i_glyph_height,
    input  logic                 i_two_bit,
    input  logic                 i_pixel_state,
    input  logic [7:0]           i_bitmap_byte,
    input  logic                 i_first_byte,
    input  logic [15:0]          i_read_address,
    output logic                 o_done,
    output logic [7:0]           o_read_data,
    output logic [3:0]           o_pixels_written,
    output logic [3:0]           o_pixels_dropped,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_data
);

    localparam int ADDR_W = gbrf_pkg::ADDR_W;
    localparam int IDX_W  = gbrf_pkg::IDX_W;
    localparam int LX_W   = gbrf_pkg::LX_W;
    localparam int LY_W   = gbrf_pkg::LY_W;
    localparam int BASE_W = gbrf_pkg::BASE_W;
    localparam int CW     = gbrf_pkg::CW;

    gbrf_pkg::t_state r_state, n_state;
    gbrf_pkg::t_cmd   r_cmd;

    logic [ADDR_W-1:0]        r_clr_addr, n_clr_addr;
    logic [1:0]               r_mode;
    logic [7:0]               r_col, n_col, r_row, n_row;
    logic [2:0]               r_k, n_k;
    logic [3:0]               r_wr, n_wr, r_dr, n_dr;
    logic [7:0]               r_bits, n_bits;
    logic signed [BASE_W-1:0] r_base_x, r_base_y;
    logic [7:0]               r_gw, r_gh;
    logic                     r_two, r_black;
    logic [15:0]              r_raddr;

    logic                     r_s1_valid, n_s1_valid;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic [7:0]               r_s1_mask;
    logic                     r_s1_black;
    logic                     r_fwd_valid;
    logic [ADDR_W-1:0]        r_fwd_addr;
    logic [7:0]               r_fwd_data;

    logic [7:0]               r_mem [gbrf_pkg::STORE_BYTES];
    logic [7:0]               r_q;

    logic                     accept;
    logic                     is_glyph;
    logic                     brk0, wrap, slot_brk, slot_last;
    logic [7:0]               ecol, erow, nx_col, nx_row;
    logic [1:0]               pix_v;
    logic                     draw, draw_black;
    logic signed [CW-1:0]     sx, sy, lx, ly;
    logic [LX_W-1:0]          lx_u;
    logic [LY_W-1:0]          ly_u;
    logic [IDX_W-1:0]         idx;
    logic                     in_bounds, pix_ok;
    logic [7:0]               pix_mask;
    logic [7:0]               s1_old, s1_new;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic [7:0]               mem_wdata;
    logic                     rd_ok;

    // glyph walk slot
    always_comb begin
        is_glyph  = (r_cmd == gbrf_pkg::CMD_GLYPH);
        brk0      = (r_gw == 8'd0) || (r_row >= r_gh);
        wrap      = !brk0 && (r_col >= r_gw);
        ecol      = wrap ? 8'd0 : r_col;
        erow      = wrap ? r_row + 8'd1 : r_row;
        slot_brk  = is_glyph && (brk0 || (wrap && (erow >= r_gh)));
        slot_last = !is_glyph || (r_k == (r_two ? 3'd3 : 3'd7));
        if ({1'b0, ecol} + 9'd1 >= {1'b0, r_gw}) begin
            nx_col = 8'd0;
            nx_row = erow + 8'd1;
        end else begin
            nx_col = ecol + 8'd1;
            nx_row = erow;
        end

        pix_v      = r_bits[7:6];
        draw       = 1'b0;
        draw_black = r_black;
        if (!is_glyph) begin
            draw = 1'b1;
        end else if (!r_two) begin
            draw = r_bits[7];
        end else begin
            case (r_mode)
                gbrf_pkg::MODE_BW: begin
                    draw = (pix_v != 2'd0);
                end
                gbrf_pkg::MODE_GRAY_MSB: begin
                    draw       = (pix_v == 2'd1);
                    draw_black = 1'b0;
                end
                gbrf_pkg::MODE_GRAY_LSB: begin
                    draw       = (pix_v == 2'd2);
                    draw_black = 1'b0;
                end
                default: begin
                    draw = 1'b0;
                end
            endcase
        end

        // portrait to landscape
        sx = CW'(r_base_x) + (is_glyph ? CW'({1'b0, ecol}) : CW'(0));
        sy = CW'(r_base_y) + (is_glyph ? CW'({1'b0, erow}) : CW'(0));
        lx = sy;
        ly = CW'(gbrf_pkg::LANDSCAPE_HEIGHT - 1) - sx;
        in_bounds = !lx[CW-1] && (lx < CW'(gbrf_pkg::LANDSCAPE_WIDTH))
                 && !ly[CW-1] && (ly < CW'(gbrf_pkg::LANDSCAPE_HEIGHT));
        lx_u     = lx[LX_W-1:0];
        ly_u     = ly[LY_W-1:0];
        idx      = IDX_W'(ly_u) * IDX_W'(gbrf_pkg::ROW_BYTES) + IDX_W'(lx_u >> 3);
        pix_ok   = in_bounds && (idx < IDX_W'(gbrf_pkg::STORE_BYTES));
        pix_mask = 8'h80 >> lx_u[2:0];
    end

    // state machine
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_col      = r_col;
        n_row      = r_row;
        n_k        = r_k;
        n_bits     = r_bits;
        n_wr       = r_wr;
        n_dr       = r_dr;
        n_s1_valid = 1'b0;
        busy       = 1'b1;
        o_done     = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            gbrf_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(gbrf_pkg::STORE_BYTES - 1)) begin
                    n_state = gbrf_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            gbrf_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    accept = 1'b1;
                    n_wr   = 4'd0;
                    n_dr   = 4'd0;
                    n_k    = 3'd0;
                    n_bits = i_bitmap_byte;
                    unique case (gbrf_pkg::t_cmd'(i_command))
                        gbrf_pkg::CMD_GLYPH: begin
                            n_state = gbrf_pkg::ST_WALK;
                            if (i_first_byte) begin
                                n_col = 8'd0;
                                n_row = 8'd0;
                            end
                        end
                        gbrf_pkg::CMD_PIXEL: n_state = gbrf_pkg::ST_WALK;
                        gbrf_pkg::CMD_READ:  n_state = gbrf_pkg::ST_READ;
                        default:             n_state = gbrf_pkg::ST_DONE;
                    endcase
                end
            end
            gbrf_pkg::ST_WALK: begin
                if (!slot_brk && draw) begin
                    n_s1_valid = pix_ok;
                    if (pix_ok) begin
                        n_wr = r_wr + 4'd1;
                    end else begin
                        n_dr = r_dr + 4'd1;
                    end
                end
                if (is_glyph) begin
                    n_col = slot_brk ? ecol : nx_col;
                    n_row = slot_brk ? erow : nx_row;
                end
                n_k    = r_k + 3'd1;
                n_bits = r_two ? {r_bits[5:0], 2'b00} : {r_bits[6:0], 1'b0};
                if (slot_brk || slot_last) begin
                    n_state = gbrf_pkg::ST_DONE;
                end
            end
            gbrf_pkg::ST_READ: begin
                n_state = gbrf_pkg::ST_DONE;
            end
            gbrf_pkg::ST_DONE: begin
                o_done  = 1'b1;
                n_state = gbrf_pkg::ST_IDLE;
            end
            default: begin
                n_state = gbrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbrf_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_mode      <= gbrf_pkg::MODE_BW;
            r_col       <= 8'd0;
            r_row       <= 8'd0;
            r_k         <= 3'd0;
            r_wr        <= 4'd0;
            r_dr        <= 4'd0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_k         <= n_k;
            r_wr        <= n_wr;
            r_dr        <= n_dr;
            r_s1_valid  <= n_s1_valid;
            r_fwd_valid <= r_s1_valid;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // item payload and write stage
    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_s1_addr  <= idx[ADDR_W-1:0];
        r_s1_mask  <= pix_mask;
        r_s1_black <= draw_black;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= s1_new;
        if (accept) begin
            r_cmd   <= gbrf_pkg::t_cmd'(i_command);
            r_gw    <= i_glyph_width;
            r_gh    <= i_glyph_height;
            r_two   <= i_two_bit;
            r_black <= i_pixel_state;
            r_raddr <= i_read_address;
            if (gbrf_pkg::t_cmd'(i_command) == gbrf_pkg::CMD_GLYPH) begin
                r_base_x <= BASE_W'(i_pen_x) + BASE_W'(i_glyph_left);
                r_base_y <= BASE_W'(i_pen_y) - BASE_W'(i_glyph_top);
            end else begin
                r_base_x <= BASE_W'(i_pen_x);
                r_base_y <= BASE_W'(i_pen_y);
            end
        end
    end

    // read-modify-write with forwarding of the previous beat's write
    always_comb begin
        s1_old    = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_q;
        s1_new    = r_s1_black ? (s1_old & ~r_s1_mask) : (s1_old | r_s1_mask);
        mem_we    = (r_state == gbrf_pkg::ST_CLEAR) || r_s1_valid;
        mem_waddr = (r_state == gbrf_pkg::ST_CLEAR) ? r_clr_addr : r_s1_addr;
        mem_wdata = (r_state == gbrf_pkg::ST_CLEAR) ? 8'hFF : s1_new;
        mem_raddr = (r_state == gbrf_pkg::ST_WALK) ? idx[ADDR_W-1:0] : ADDR_W'(r_raddr);
        rd_ok     = (32'(r_raddr) < 32'(gbrf_pkg::STORE_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[mem_raddr];
    end

    assign o_cfg_ready      = 1'b1;
    assign o_read_data      = ((r_cmd == gbrf_pkg::CMD_READ) && rd_ok) ? r_q : 8'd0;
    assign o_pixels_written = r_wr;
    assign o_pixels_dropped = r_dr;

    `ASSERT_AT(a_done_while_busy, i_clk, i_rst_n, o_done |-> busy, "result outside busy")
    `ASSERT_AT(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "result strobe repeated")
    `ASSERT_AT(a_count_limit, i_clk, i_rst_n, o_done |-> (5'(r_wr) + 5'(r_dr) <= 5'd8), "too many pixels")
    `ASSERT_AT(a_write_after_walk, i_clk, i_rst_n, r_s1_valid |-> $past(r_state == gbrf_pkg::ST_WALK), "write beat without walk")
    `ASSERT_NEVER(a_clear_no_rmw, i_clk, i_rst_n, (r_state == gbrf_pkg::ST_CLEAR) && r_s1_valid, "pixel write during clear")

endmodule

FILE: tb/tb_top.sv
// testbench for glyph_blit_rotated_framebuffer: directed table, then random glyph runs, pixel
// writes, byte reads and unused commands, scored against a behavioral copy of the framebuffer
// or against results given in the table; depends on gbrf_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        gbrf_pkg::t_cmd     cmd;
        logic signed [10:0] px;
        logic signed [10:0] py;
        logic signed [7:0]  left;
        logic signed [7:0]  top;
        logic [7:0]         gw;
        logic [7:0]         gh;
        logic [7:0]         bmp;
        bit                 two;
        bit                 black;
        bit                 first;
        logic [15:0]        addr;
        bit                 typed;
        logic [7:0]         rd;
        logic [3:0]         wr;
        logic [3:0]         dr;
    } t_blit_req;

    typedef struct {
        logic [7:0] rd;
        logic [3:0] wr;
        logic [3:0] dr;
    } t_blit_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic signed [10:0] i_pen_x;
    logic signed [10:0] i_pen_y;
    logic signed [7:0]  i_glyph_left;
    logic signed [7:0]  i_glyph_top;
    logic [7:0]         i_glyph_width;
    logic [7:0]         i_glyph_height;
    logic               i_two_bit;
    logic               i_pixel_state;
    logic [7:0]         i_bitmap_byte;
    logic               i_first_byte;
    logic [15:0]        i_read_address;
    logic               o_done;
    logic [7:0]         o_read_data;
    logic [3:0]         o_pixels_written;
    logic [3:0]         o_pixels_dropped;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_data;

    glyph_blit_rotated_framebuffer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_pen_x          (i_pen_x),
        .i_pen_y          (i_pen_y),
        .i_glyph_left     (i_glyph_left),
        .i_glyph_top      (i_glyph_top),
        .i_glyph_width    (i_glyph_width),
        .i_glyph_height   (i_glyph_height),
        .i_two_bit        (i_two_bit),
        .i_pixel_state    (i_pixel_state),
        .i_bitmap_byte    (i_bitmap_byte),
        .i_first_byte     (i_first_byte),
        .i_read_address   (i_read_address),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_pixels_written (o_pixels_written),
        .o_pixels_dropped (o_pixels_dropped),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // shadow framebuffer and glyph walk
    logic [7:0] shadow_fb [0:gbrf_pkg::STORE_BYTES-1];
    logic [7:0] walk_col;
    logic [7:0] walk_row;
    logic [1:0] shadow_mode;

    t_blit_res  pending_results[$];
    t_blit_req  cur_req;
    t_blit_req  dir_tab[$];
    int         n_accepted;
    int         n_cfg_beats;
    int         n_errors;
    int         n_sent;
    int         idle_pct;
    int         last_x;
    int         last_y;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic flag_error(input string what);
        n_errors++;
        if (n_errors <= 60) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic bit paint_pixel(input int x, input int y, input bit black);
        int lx;
        int ly;
        int idx;
        lx = y;
        ly = gbrf_pkg::LANDSCAPE_HEIGHT - 1 - x;
        if (lx < 0 || lx >= gbrf_pkg::LANDSCAPE_WIDTH || ly < 0
            || ly >= gbrf_pkg::LANDSCAPE_HEIGHT) begin
            return 1'b0;
        end
        idx = ly * gbrf_pkg::ROW_BYTES + lx / 8;
        if (idx >= gbrf_pkg::STORE_BYTES) begin
            return 1'b0;
        end
        shadow_fb[idx][7 - (lx % 8)] = ~black;
        return 1'b1;
    endfunction

    task automatic predict_blit(input t_blit_req r, output t_blit_res q);
        int         slots;
        int         k;
        bit         draw;
        bit         blk;
        logic [1:0] v;
        q = '{8'd0, 4'd0, 4'd0};
        case (r.cmd)
            gbrf_pkg::CMD_GLYPH: begin
                slots = r.two ? 4 : 8;
                if (r.first) begin
                    walk_col = 8'd0;
                    walk_row = 8'd0;
                end
                for (k = 0; k < slots; k++) begin
                    if (r.gw == 8'd0 || walk_row >= r.gh) break;
                    if (walk_col >= r.gw) begin
                        walk_col = 8'd0;
                        walk_row = walk_row + 8'd1;
                        if (walk_row >= r.gh) break;
                    end
                    draw = 1'b0;
                    blk  = r.black;
                    if (r.two) begin
                        v = 2'((r.bmp >> (6 - 2 * k)) & 8'h3);
                        if (shadow_mode == gbrf_pkg::MODE_BW && v != 2'd0) begin
                            draw = 1'b1;
                        end else if (shadow_mode == gbrf_pkg::MODE_GRAY_MSB && v == 2'd1) begin
                            draw = 1'b1;
                            blk  = 1'b0;
                        end else if (shadow_mode == gbrf_pkg::MODE_GRAY_LSB && v == 2'd2) begin
                            draw = 1'b1;
                            blk  = 1'b0;
                        end
                    end else begin
                        draw = r.bmp[7 - k];
                    end
                    if (draw) begin
                        if (paint_pixel(int'(r.px) + int'(r.left) + int'(walk_col),
                                        int'(r.py) - int'(r.top) + int'(walk_row), blk)) begin
                            q.wr++;
                        end else begin
                            q.dr++;
                        end
                    end
                    if (int'(walk_col) + 1 >= int'(r.gw)) begin
                        walk_col = 8'd0;
                        walk_row = walk_row + 8'd1;
                    end else begin
                        walk_col = walk_col + 8'd1;
                    end
                end
            end
            gbrf_pkg::CMD_PIXEL: begin
                if (paint_pixel(int'(r.px), int'(r.py), r.black)) begin
                    q.wr = 4'd1;
                end else begin
                    q.dr = 4'd1;
                end
            end
            gbrf_pkg::CMD_READ: begin
                if (int'(r.addr) < gbrf_pkg::STORE_BYTES) begin
                    q.rd = shadow_fb[r.addr];
                end
            end
            default: ;
        endcase
    endtask

    // scoreboard: results first, then the beat accepted on the same edge
    always @(posedge i_clk) begin : score
        t_blit_res want;
        t_blit_res calc;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    flag_error("result with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_data !== want.rd) begin
                        flag_error($sformatf("read_data %h, want %h", o_read_data, want.rd));
                    end
                    if (o_pixels_written !== want.wr) begin
                        flag_error($sformatf("pixels_written %0d, want %0d",
                                             o_pixels_written, want.wr));
                    end
                    if (o_pixels_dropped !== want.dr) begin
                        flag_error($sformatf("pixels_dropped %0d, want %0d",
                                             o_pixels_dropped, want.dr));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_mode = i_cfg_data;
                n_cfg_beats++;
            end
            if (start && !busy) begin
                predict_blit(cur_req, calc);
                if (cur_req.typed) begin
                    calc = '{cur_req.rd, cur_req.wr, cur_req.dr};
                end
                pending_results.push_back(calc);
                n_accepted++;
            end
        end
    end

    function automatic t_blit_req rand_req();
        t_blit_req r;
        r.cmd   = gbrf_pkg::t_cmd'($urandom_range(3));
        r.px    = 11'($urandom);
        r.py    = 11'($urandom);
        r.left  = 8'($urandom);
        r.top   = 8'($urandom);
        r.gw    = 8'($urandom);
        r.gh    = 8'($urandom);
        r.bmp   = 8'($urandom);
        r.two   = 1'($urandom);
        r.black = 1'($urandom);
        r.first = 1'($urandom);
        r.addr  = 16'($urandom);
        r.typed = 1'b0;
        r.rd    = 8'd0;
        r.wr    = 4'd0;
        r.dr    = 4'd0;
        return r;
    endfunction

    function automatic t_blit_req dir_row(input gbrf_pkg::t_cmd c, input int px, input int py,
                                          input int left, input int top, input int gw,
                                          input int gh, input bit two, input bit black,
                                          input int bmp, input bit first, input int addr,
                                          input bit typed, input int rd, input int wr,
                                          input int dr);
        t_blit_req r;
        r.cmd   = c;
        r.px    = px[10:0];
        r.py    = py[10:0];
        r.left  = left[7:0];
        r.top   = top[7:0];
        r.gw    = gw[7:0];
        r.gh    = gh[7:0];
        r.two   = two;
        r.black = black;
        r.bmp   = bmp[7:0];
        r.first = first;
        r.addr  = addr[15:0];
        r.typed = typed;
        r.rd    = rd[7:0];
        r.wr    = wr[3:0];
        r.dr    = dr[3:0];
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_req(input t_blit_req r);
        int gap;
        int taken;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_req = r;
        i_command      <= r.cmd;
        i_pen_x        <= r.px;
        i_pen_y        <= r.py;
        i_glyph_left   <= r.left;
        i_glyph_top    <= r.top;
        i_glyph_width  <= r.gw;
        i_glyph_height <= r.gh;
        i_two_bit      <= r.two;
        i_pixel_state  <= r.black;
        i_bitmap_byte  <= r.bmp;
        i_first_byte   <= r.first;
        i_read_address <= r.addr;
        start          <= 1'b1;
        taken = n_accepted;
        do @(negedge i_clk); while (n_accepted == taken);
        n_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_mode(input logic [1:0] m);
        int taken;
        wait_drained();
        repeat (12) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        taken = n_cfg_beats;
        do @(negedge i_clk); while (n_cfg_beats == taken);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 2'($urandom);
    endtask

    task automatic send_glyph_run();
        t_blit_req r;
        int        w;
        int        h;
        int        slots;
        int        nbytes;
        int        k;
        r = rand_req();
        r.cmd = gbrf_pkg::CMD_GLYPH;
        w = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(255);
        h = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(255);
        r.gw = w[7:0];
        r.gh = h[7:0];
        if ($urandom_range(99) < 85) begin
            r.px   = 11'($urandom_range(520) - 20);
            r.py   = 11'($urandom_range(840) - 20);
            r.left = 8'($urandom_range(8) - 4);
            r.top  = 8'($urandom_range(16));
        end
        last_x = int'(r.px) + int'(r.left);
        last_y = int'(r.py) - int'(r.top);
        slots  = r.two ? 4 : 8;
        nbytes = (w * h + slots - 1) / slots;
        if (nbytes > 20) nbytes = 20;
        if ($urandom_range(99) < 10) nbytes += $urandom_range(1, 2);
        if (nbytes == 0) nbytes = 1;
        for (k = 0; k < nbytes; k++) begin
            // a few runs start without the restart flag or change width mid glyph
            r.first = (k == 0) && ($urandom_range(99) >= 5);
            r.bmp   = 8'($urandom);
            if (k > 0 && $urandom_range(99) < 4) begin
                r.gw = 8'($urandom_range(1, 12));
            end
            send_req(r);
        end
    endtask

    task automatic run_phase(input int n_items, input int pct);
        t_blit_req r;
        int        sel;
        int        x;
        int        y;
        int        stop_at;
        idle_pct = pct;
        stop_at  = n_sent + n_items;
        while (n_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                send_glyph_run();
            end else if (sel < 70) begin
                r = rand_req();
                r.cmd = gbrf_pkg::CMD_PIXEL;
                if ($urandom_range(99) < 80) begin
                    r.px = 11'($urandom_range(500) - 10);
                    r.py = 11'($urandom_range(820) - 10);
                end
                send_req(r);
            end else if (sel < 92) begin
                r = rand_req();
                r.cmd = gbrf_pkg::CMD_READ;
                sel = $urandom_range(99);
                if (sel < 55) begin
                    // read back around the last glyph
                    x = last_x + $urandom_range(11);
                    y = last_y + $urandom_range(11);
                    if (x >= 0 && x < gbrf_pkg::LANDSCAPE_HEIGHT && y >= 0
                        && y < gbrf_pkg::LANDSCAPE_WIDTH) begin
                        r.addr = 16'((gbrf_pkg::LANDSCAPE_HEIGHT - 1 - x) * gbrf_pkg::ROW_BYTES
                                     + y / 8);
                    end else begin
                        r.addr = 16'($urandom_range(gbrf_pkg::STORE_BYTES - 1));
                    end
                end else if (sel < 85) begin
                    r.addr = 16'($urandom_range(gbrf_pkg::STORE_BYTES - 1));
                end
                send_req(r);
            end else begin
                r = rand_req();
                r.cmd = gbrf_pkg::CMD_NOP;
                send_req(r);
            end
            if ($urandom_range(99) < 2) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'hFF;
        walk_col    = 8'd0;
        walk_row    = 8'd0;
        shadow_mode = gbrf_pkg::MODE_BW;
        n_accepted  = 0;
        n_cfg_beats = 0;
        n_errors    = 0;
        n_sent      = 0;
        idle_pct    = 0;
        last_x      = 0;
        last_y      = 0;
        cur_req     = rand_req();

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = gbrf_pkg::CMD_NOP;
        i_pen_x        = '0;
        i_pen_y        = '0;
        i_glyph_left   = '0;
        i_glyph_top    = '0;
        i_glyph_width  = '0;
        i_glyph_height = '0;
        i_two_bit      = 1'b0;
        i_pixel_state  = 1'b0;
        i_bitmap_byte  = '0;
        i_first_byte   = 1'b0;
        i_read_address = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = gbrf_pkg::MODE_BW;

        // fields: cmd px py left top gw gh two black bmp first addr | typed rd wr dr
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, 'hFF, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 47999,
                                  1, 'hFF, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48000,
                                  1, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535,
                                  1, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_NOP, -1, -1, -1, -1, 255, 255, 1, 1, 255, 1,
                                  65535, 1, 0, 0, 0));
        // portrait corners of the screen
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                  1, 0, 1, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 47900,
                                  1, 'h7F, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 479, 799, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                  1, 0, 1, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 99,
                                  1, 'hFE, 0, 0));
        // off screen, then the first corner painted back to white
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 480, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                  1, 0, 0, 1));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, -1024, -1024, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                  1, 0, 0, 1));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, 0, 0, 1));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 0, 800, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                                  1, 0, 0, 1));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, 0, 1, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 47900,
                                  1, 'hFF, 0, 0));
        // glyph walk, then padding once the rows are used up
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 10, 20, 0, 0, 8, 2, 0, 1, 'hFF, 1, 0,
                                  1, 0, 8, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 10, 20, 0, 0, 8, 2, 0, 1, 'hA5, 0, 0,
                                  0, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 10, 20, 0, 0, 8, 2, 0, 1, 'hFF, 0, 0,
                                  1, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 46902,
                                  0, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 10, 20, 0, 0, 0, 5, 0, 1, 'hFF, 1, 0,
                                  1, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 100, 100, 0, 0, 4, 1, 1, 1, 'h1B, 1, 0,
                                  0, 0, 0, 0));
        // extreme metrics, all off screen
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, -1024, -1024, -128, 127, 255, 255, 0, 1,
                                  'hFF, 1, 0, 1, 0, 0, 8));
        // glyph straddling the portrait right edge
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 475, 0, 0, 0, 8, 1, 0, 1, 'hFF, 1, 0,
                                  1, 0, 5, 3));
        // width shrinks mid glyph
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 200, 300, 3, 5, 6, 3, 0, 1, 'hFF, 1, 0,
                                  0, 0, 0, 0));
        dir_tab.push_back(dir_row(gbrf_pkg::CMD_GLYPH, 200, 300, 3, 5, 2, 3, 0, 0, 'hFF, 0, 0,
                                  0, 0, 0, 0));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_req(dir_tab[i]);

        write_mode(gbrf_pkg::MODE_GRAY_LSB);
        run_phase(170, 0);
        write_mode(gbrf_pkg::MODE_GRAY_MSB);
        run_phase(165, 73);
        write_mode(gbrf_pkg::MODE_OFF);
        run_phase(165, 12);
        write_mode(gbrf_pkg::MODE_BW);
        run_phase(165, 0);
        write_mode(gbrf_pkg::MODE_GRAY_LSB);
        run_phase(160, 73);

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/gbrf_pkg.sv
sv/glyph_blit_rotated_framebuffer.sv
tb/tb_top.sv
